### rtl/vbsc_pkg.sv
// Shared types and constants for the variable bin split cost unit.
`timescale 1ns / 1ps
package vbsc_pkg;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int CAP_W        = 16;
    localparam int COST_W       = 16;
    localparam int TOTAL_W      = 44;
    localparam int ITEM_INDEX_W = 6;
    localparam int BIN_NUMBER_W = 7;
    localparam int STATUS_W     = 2;
    localparam int JOB_N_W      = 9;
    localparam int SQ_IN_W      = 22;

    localparam logic [TOTAL_W-1:0] COST_MAX      = 44'hFFF_FFFF_FFFF;
    localparam logic [TOTAL_W-1:0] IDLE_SQ_LIMIT = 44'd4194304;

    localparam logic [CFG_IDX_W-1:0] CFG_CAP_SMALL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_MEDIUM  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_LARGE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COST_SMALL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COST_MEDIUM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COST_LARGE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_EN  = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPLIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY = 2'd2;

    typedef struct packed {
        logic [15:0] item_weight;
        logic        last_item;
    } in_t;

    typedef struct packed {
        logic [ITEM_INDEX_W-1:0] item_index;
        logic [BIN_NUMBER_W-1:0] bin_number;
        logic [TOTAL_W-1:0]      total_cost;
        logic [STATUS_W-1:0]     status;
        logic                    last_result;
    } out_t;

    typedef struct packed {
        logic [CAP_W-1:0]  cap_s;
        logic [CAP_W-1:0]  cap_m;
        logic [CAP_W-1:0]  cap_l;
        logic [COST_W-1:0] cost_s;
        logic [COST_W-1:0] cost_m;
        logic [COST_W-1:0] cost_l;
        logic              pen_en;
    } cfg_t;

    typedef struct packed {
        logic               too_many;
        logic [JOB_N_W-1:0] n;
    } job_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_ROW_RD,
        B_ROW_LD,
        B_COL_RD,
        B_COL_EV,
        B_COL_WR,
        B_FIN,
        B_WB_RD,
        B_WB_RP,
        B_WB_EV,
        B_PEN_MUL,
        B_PEN_ADD,
        B_EM_RD,
        B_EM_LD,
        B_EM_OUT,
        B_STATUS
    } back_state_t;

endpackage

### rtl/vbsc_front.sv
// Front end: takes item beats, builds prefix sums and issues jobs.
`timescale 1ns / 1ps
module vbsc_front #(
    parameter int MAX_ITEMS   = 64,
    parameter int WEIGHT_BITS = 16,
    localparam int NW = $clog2(MAX_ITEMS + 1),
    localparam int PW = WEIGHT_BITS + NW
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vbsc_pkg::in_t   item,
    output logic            full,
    output logic            pw_en,
    output logic [NW-1:0]   pw_addr,
    output logic [PW-1:0]   pw_data,
    output logic            job_push,
    output vbsc_pkg::job_t  job,
    input  logic            q_full,
    input  logic            run_done
);
    import vbsc_pkg::*;

    logic [NW-1:0]          count_reg, count_next;
    logic [PW-1:0]          sum_reg, sum_next;
    logic                   ovf_reg, ovf_next;
    logic                   lock_reg, lock_next;
    logic                   accept;
    logic                   room;
    logic [WEIGHT_BITS-1:0] w;

    assign full   = lock_reg || q_full;
    assign accept = push && !full;
    assign room   = count_reg < NW'(MAX_ITEMS);
    assign w      = WEIGHT_BITS'(item.item_weight);

    assign pw_en   = accept && room;
    assign pw_addr = count_reg + NW'(1);
    assign pw_data = sum_reg + PW'(w);

    assign job_push    = accept && item.last_item;
    assign job.too_many = ovf_reg || !room;
    assign job.n       = JOB_N_W'(count_reg + NW'(room));

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        lock_next  = lock_reg;
        if (run_done)
        begin
            lock_next = 1'b0;
        end
        if (accept)
        begin
            if (item.last_item)
            begin
                count_next = '0;
                sum_next   = '0;
                ovf_next   = 1'b0;
                // hold off new items until the run releases the prefix store
                lock_next  = !job.too_many;
            end
            else if (room)
            begin
                count_next = count_reg + NW'(1);
                sum_next   = pw_data;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            lock_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
            lock_reg  <= lock_next;
        end
    end

endmodule

### rtl/vbsc_queue.sv
// Two-entry job queue between the front end and the solver.
`timescale 1ns / 1ps
module vbsc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  vbsc_pkg::job_t wdata,
    output logic           full,
    input  logic           rd,
    output vbsc_pkg::job_t rdata,
    output logic           empty
);
    import vbsc_pkg::*;

    job_t       slot_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = slot_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ do_wr;
        rp_next  = rp_reg ^ do_rd;
        cnt_next = cnt_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### rtl/vbsc_back.sv
// Solver: shortest-path split over prefix sums, walk-back and result emission.
`timescale 1ns / 1ps
module vbsc_back #(
    parameter int MAX_ITEMS   = 64,
    parameter int WEIGHT_BITS = 16,
    localparam int NW = $clog2(MAX_ITEMS + 1),
    localparam int PW = WEIGHT_BITS + NW
) (
    input  logic           clk,
    input  logic           rst_n,
    input  vbsc_pkg::cfg_t cfg,
    input  logic           pw_en,
    input  logic [NW-1:0]  pw_addr,
    input  logic [PW-1:0]  pw_data,
    input  logic           q_empty,
    input  vbsc_pkg::job_t q_job,
    output logic           job_pop,
    output logic           run_done,
    output vbsc_pkg::out_t res,
    output logic           res_valid,
    input  logic           pop
);
    import vbsc_pkg::*;

    localparam int JW   = $clog2(MAX_ITEMS + 2);
    localparam int CW   = COST_W + NW;
    localparam int IW   = CAP_W + NW;
    localparam int SW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CMPW = PW + CAP_W;

    typedef struct packed {
        logic              fit;
        logic [COST_W-1:0] cost;
        logic [CAP_W-1:0]  idle;
    } pick_t;

    function automatic pick_t pick_bin(input logic [PW-1:0] seg, input cfg_t c);
        logic [CMPW-1:0] s;
        pick_t           r;
        s = CMPW'(seg);
        r = '0;
        if (s <= CMPW'(c.cap_s))
        begin
            r.fit  = 1'b1;
            r.cost = c.cost_s;
            r.idle = CAP_W'(CMPW'(c.cap_s) - s);
        end
        else if (s <= CMPW'(c.cap_m))
        begin
            r.fit  = 1'b1;
            r.cost = c.cost_m;
            r.idle = CAP_W'(CMPW'(c.cap_m) - s);
        end
        else if (s <= CMPW'(c.cap_l))
        begin
            r.fit  = 1'b1;
            r.cost = c.cost_l;
            r.idle = CAP_W'(CMPW'(c.cap_l) - s);
        end
        return r;
    endfunction

    logic [PW-1:0] prefix_mem [MAX_ITEMS+1];
    logic [CW-1:0] cost_mem   [MAX_ITEMS+1];
    logic [NW-1:0] pred_mem   [MAX_ITEMS+1];
    logic [NW-1:0] stack_mem  [MAX_ITEMS];

    back_state_t        state_reg, state_next;
    logic [MAX_ITEMS:0] valid_reg, valid_next;
    logic               res_valid_reg, res_valid_next;
    logic               run_reg, run_next;

    logic [NW-1:0]      n_reg, n_next;
    logic [NW-1:0]      i_reg, i_next;
    logic [JW-1:0]      j_reg, j_next;
    logic [PW-1:0]      pi_reg, pi_next;
    logic [CW-1:0]      ci_reg, ci_next;
    logic [COST_W-1:0]  binc_reg, binc_next;
    logic [NW-1:0]      node_reg, node_next;
    logic [PW-1:0]      pn_reg, pn_next;
    logic [NW-1:0]      bins_reg, bins_next;
    logic [IW-1:0]      idle_reg, idle_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [TOTAL_W-1:0] sq_reg, sq_next;
    logic               sat_reg, sat_next;
    logic [NW-1:0]      end_reg, end_next;
    logic [NW-1:0]      bin_reg, bin_next;
    logic [STATUS_W-1:0] code_reg, code_next;
    out_t               res_reg, res_next;

    logic [PW-1:0]      p_rd_reg;
    logic               p_zero_reg;
    logic [CW-1:0]      c_rd_reg;
    logic [NW-1:0]      pr_rd_reg;
    logic [NW-1:0]      s_rd_reg;

    logic               p_ren, c_ren, pr_ren, s_ren, c_we, s_we;
    logic [NW-1:0]      p_raddr, c_raddr;
    logic [SW-1:0]      s_raddr;

    logic [PW-1:0]      p_rd_eff;
    pick_t              col_pick, wb_pick;
    logic [CW-1:0]      cand;
    logic               better;
    logic               row_skip;
    logic               free;
    logic               last_out;
    logic [TOTAL_W-1:0] pen;

    assign p_rd_eff = p_zero_reg ? '0 : p_rd_reg;
    assign col_pick = pick_bin(p_rd_eff - pi_reg, cfg);
    assign wb_pick  = pick_bin(pn_reg - p_rd_eff, cfg);
    assign cand     = ci_reg + CW'(binc_reg);
    assign better   = !valid_reg[NW'(j_reg)] || (cand < c_rd_reg);
    assign row_skip = (i_reg != '0) && !valid_reg[i_reg];
    assign free     = !res_valid_reg || pop;
    assign last_out = (j_reg + JW'(1)) == JW'(n_reg);
    assign pen      = sat_reg ? COST_MAX : sq_reg;

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = q_job.too_many ? B_STATUS : B_ROW_RD;
                end
            end
            B_ROW_RD:
            begin
                if (i_reg == n_reg)
                begin
                    state_next = B_FIN;
                end
                else if (!row_skip)
                begin
                    state_next = B_ROW_LD;
                end
            end
            B_ROW_LD: state_next = B_COL_RD;
            B_COL_RD: state_next = (j_reg > JW'(n_reg)) ? B_ROW_RD : B_COL_EV;
            B_COL_EV: state_next = col_pick.fit ? B_COL_WR : B_ROW_RD;
            B_COL_WR: state_next = B_COL_RD;
            B_FIN:    state_next = valid_reg[n_reg] ? B_WB_RD : B_STATUS;
            B_WB_RD:  state_next = B_WB_RP;
            B_WB_RP:  state_next = B_WB_EV;
            B_WB_EV:  state_next = (pr_rd_reg == '0) ? B_PEN_MUL : B_WB_RD;
            B_PEN_MUL: state_next = cfg.pen_en ? B_PEN_ADD : B_EM_RD;
            B_PEN_ADD: state_next = B_EM_RD;
            B_EM_RD:  state_next = B_EM_LD;
            B_EM_LD:  state_next = B_EM_OUT;
            B_EM_OUT:
            begin
                if (free)
                begin
                    if (last_out)
                    begin
                        state_next = B_IDLE;
                    end
                    else if ((j_reg + JW'(1)) == JW'(end_reg))
                    begin
                        state_next = B_EM_RD;
                    end
                end
            end
            B_STATUS:
            begin
                if (free)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        valid_next     = valid_reg;
        res_valid_next = res_valid_reg && !pop;
        run_next       = run_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        pi_next        = pi_reg;
        ci_next        = ci_reg;
        binc_next      = binc_reg;
        node_next      = node_reg;
        pn_next        = pn_reg;
        bins_next      = bins_reg;
        idle_next      = idle_reg;
        total_next     = total_reg;
        sq_next        = sq_reg;
        sat_next       = sat_reg;
        end_next       = end_reg;
        bin_next       = bin_reg;
        code_next      = code_reg;
        res_next       = res_reg;
        p_ren          = 1'b0;
        c_ren          = 1'b0;
        pr_ren         = 1'b0;
        s_ren          = 1'b0;
        c_we           = 1'b0;
        s_we           = 1'b0;
        p_raddr        = '0;
        c_raddr        = '0;
        s_raddr        = '0;
        job_pop        = 1'b0;
        run_done       = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    job_pop    = 1'b1;
                    run_next   = !q_job.too_many;
                    n_next     = NW'(q_job.n);
                    i_next     = '0;
                    valid_next = '0;
                    code_next  = ST_TOO_MANY;
                end
            end
            B_ROW_RD:
            begin
                if (i_reg == n_reg)
                begin
                    c_ren   = 1'b1;
                    c_raddr = n_reg;
                end
                else if (row_skip)
                begin
                    i_next = i_reg + NW'(1);
                end
                else
                begin
                    p_ren   = 1'b1;
                    p_raddr = i_reg;
                    c_ren   = 1'b1;
                    c_raddr = i_reg;
                end
            end
            B_ROW_LD:
            begin
                pi_next = p_rd_eff;
                // the start node costs nothing and is never written
                ci_next = (i_reg == '0) ? '0 : c_rd_reg;
                j_next  = JW'(i_reg) + JW'(1);
            end
            B_COL_RD:
            begin
                if (j_reg > JW'(n_reg))
                begin
                    i_next = i_reg + NW'(1);
                end
                else
                begin
                    p_ren   = 1'b1;
                    p_raddr = NW'(j_reg);
                    c_ren   = 1'b1;
                    c_raddr = NW'(j_reg);
                end
            end
            B_COL_EV:
            begin
                if (col_pick.fit)
                begin
                    binc_next = col_pick.cost;
                end
                else
                begin
                    i_next = i_reg + NW'(1);
                end
            end
            B_COL_WR:
            begin
                if (better)
                begin
                    c_we                    = 1'b1;
                    valid_next[NW'(j_reg)]  = 1'b1;
                end
                j_next = j_reg + JW'(1);
            end
            B_FIN:
            begin
                if (valid_reg[n_reg])
                begin
                    total_next = TOTAL_W'(c_rd_reg);
                    node_next  = n_reg;
                    bins_next  = '0;
                    idle_next  = '0;
                end
                else
                begin
                    code_next = ST_NO_SPLIT;
                end
            end
            B_WB_RD:
            begin
                pr_ren  = 1'b1;
                p_ren   = 1'b1;
                p_raddr = node_reg;
            end
            B_WB_RP:
            begin
                pn_next = p_rd_eff;
                p_ren   = 1'b1;
                p_raddr = pr_rd_reg;
            end
            B_WB_EV:
            begin
                idle_next = idle_reg + IW'(wb_pick.idle);
                s_we      = 1'b1;
                bins_next = bins_reg + NW'(1);
                node_next = pr_rd_reg;
            end
            B_PEN_MUL:
            begin
                sat_next = TOTAL_W'(idle_reg) >= IDLE_SQ_LIMIT;
                sq_next  = TOTAL_W'(SQ_IN_W'(idle_reg)) * TOTAL_W'(SQ_IN_W'(idle_reg));
                bin_next = bins_reg;
                j_next   = '0;
            end
            B_PEN_ADD:
            begin
                if (pen > (COST_MAX - total_reg))
                begin
                    total_next = COST_MAX;
                end
                else
                begin
                    total_next = total_reg + pen;
                end
            end
            B_EM_RD:
            begin
                s_ren   = 1'b1;
                s_raddr = SW'(bin_reg - NW'(1));
            end
            B_EM_LD:
            begin
                end_next = s_rd_reg;
            end
            B_EM_OUT:
            begin
                if (free)
                begin
                    res_next.item_index  = ITEM_INDEX_W'(j_reg);
                    res_next.bin_number  = BIN_NUMBER_W'(bin_reg);
                    res_next.total_cost  = total_reg;
                    res_next.status      = ST_OK;
                    res_next.last_result = last_out;
                    res_valid_next       = 1'b1;
                    j_next               = j_reg + JW'(1);
                    if (last_out)
                    begin
                        run_done = 1'b1;
                    end
                    else if ((j_reg + JW'(1)) == JW'(end_reg))
                    begin
                        bin_next = bin_reg - NW'(1);
                    end
                end
            end
            B_STATUS:
            begin
                if (free)
                begin
                    res_next             = '0;
                    res_next.status      = code_reg;
                    res_next.last_result = 1'b1;
                    res_valid_next       = 1'b1;
                    run_done             = run_reg;
                end
            end
            default:
            begin
                res_valid_next = res_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pw_en)
        begin
            prefix_mem[pw_addr] <= pw_data;
        end
        if (p_ren)
        begin
            p_rd_reg   <= prefix_mem[p_raddr];
            p_zero_reg <= p_raddr == '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            cost_mem[NW'(j_reg)] <= cand;
        end
        if (c_ren)
        begin
            c_rd_reg <= cost_mem[c_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            pred_mem[NW'(j_reg)] <= i_reg;
        end
        if (pr_ren)
        begin
            pr_rd_reg <= pred_mem[node_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            stack_mem[SW'(bins_reg)] <= node_reg;
        end
        if (s_ren)
        begin
            s_rd_reg <= stack_mem[s_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        pi_reg    <= pi_next;
        ci_reg    <= ci_next;
        binc_reg  <= binc_next;
        node_reg  <= node_next;
        pn_reg    <= pn_next;
        bins_reg  <= bins_next;
        idle_reg  <= idle_next;
        total_reg <= total_next;
        sq_reg    <= sq_next;
        sat_reg   <= sat_next;
        end_reg   <= end_next;
        bin_reg   <= bin_next;
        code_reg  <= code_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
            run_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            res_valid_reg <= res_valid_next;
            run_reg       <= run_next;
        end
    end

endmodule

### rtl/variable_bin_split_cost_unit.sv
// Top level of the variable bin split cost unit: config registers and wiring.
`timescale 1ns / 1ps
// Items load at one beat per cycle while no run is pending and the job queue
// has room; the beat marked last queues a job and, unless the sequence is too
// long, holds off further items until that run has delivered its final result.
// A run relaxes the segments from each reachable node, walks back over the
// chosen bins, works out the penalty (adding it only when it is enabled) and
// then delivers one result per item. The relaxation loop over the path cost
// memory sets the pace. A sequence longer than MAX_ITEMS, or one with no
// feasible split, yields one status beat.
module variable_bin_split_cost_unit #(
    parameter int MAX_ITEMS   = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  vbsc_pkg::in_t                       item,
    output logic                                full,
    output logic                                empty,
    input  logic                                pop,
    output vbsc_pkg::out_t                      result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vbsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vbsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import vbsc_pkg::*;

    localparam int NW = $clog2(MAX_ITEMS + 1);
    localparam int PW = WEIGHT_BITS + NW;

    cfg_t          cfg_reg, cfg_next;
    logic          pw_en;
    logic [NW-1:0] pw_addr;
    logic [PW-1:0] pw_data;
    logic          job_push, job_pop, q_full, q_empty, run_done;
    job_t          job_in, job_out;
    logic          res_valid;

    assign cfg_ready = 1'b1;
    assign empty     = !res_valid;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CAP_SMALL:   cfg_next.cap_s  = cfg_data;
                CFG_CAP_MEDIUM:  cfg_next.cap_m  = cfg_data;
                CFG_CAP_LARGE:   cfg_next.cap_l  = cfg_data;
                CFG_COST_SMALL:  cfg_next.cost_s = cfg_data;
                CFG_COST_MEDIUM: cfg_next.cost_m = cfg_data;
                CFG_COST_LARGE:  cfg_next.cost_l = cfg_data;
                CFG_PENALTY_EN:  cfg_next.pen_en = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    vbsc_front #(
        .MAX_ITEMS   (MAX_ITEMS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .pw_en    (pw_en),
        .pw_addr  (pw_addr),
        .pw_data  (pw_data),
        .job_push (job_push),
        .job      (job_in),
        .q_full   (q_full),
        .run_done (run_done)
    );

    vbsc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (job_push),
        .wdata (job_in),
        .full  (q_full),
        .rd    (job_pop),
        .rdata (job_out),
        .empty (q_empty)
    );

    vbsc_back #(
        .MAX_ITEMS   (MAX_ITEMS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pw_en     (pw_en),
        .pw_addr   (pw_addr),
        .pw_data   (pw_data),
        .q_empty   (q_empty),
        .q_job     (job_out),
        .job_pop   (job_pop),
        .run_done  (run_done),
        .res       (result),
        .res_valid (res_valid),
        .pop       (pop)
    );

`ifndef ASSERT_OFF
    a_ok_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status == ST_OK) |-> (result.bin_number != '0))
        else $error("ok result without a bin");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status != ST_OK) |-> result.last_result)
        else $error("status beat not marked last");

    a_done_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        run_done |-> !pw_en)
        else $error("prefix write while a run finishes");
`endif

endmodule

### dv/variable_bin_split_cost_checker.sv
// Checker for the variable bin split cost unit: predicts each run's beats and compares them.
`timescale 1ns / 1ps
module variable_bin_split_cost_checker #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  logic                            full,
    input  vbsc_pkg::in_t                   item,
    input  logic                            pop,
    input  logic                            empty,
    input  vbsc_pkg::out_t                  result,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [vbsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vbsc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              errors,
    output int                              pending
);
    import vbsc_pkg::*;

    longint unsigned cap_s, cap_m, cap_l, cost_s, cost_m, cost_l;
    bit              pen_en;
    logic [15:0]     loaded[MAX_ITEMS];
    int              loaded_cnt;
    bit              dropped;
    out_t            split_q[$];

    assign pending = split_q.size();

    function automatic bit fit_bin(input longint unsigned seg,
                                   output longint unsigned c,
                                   output longint unsigned idle);
        c    = 0;
        idle = 0;
        if (seg <= cap_s) begin c = cost_s; idle = cap_s - seg; return 1; end
        if (seg <= cap_m) begin c = cost_m; idle = cap_m - seg; return 1; end
        if (seg <= cap_l) begin c = cost_l; idle = cap_l - seg; return 1; end
        return 0;
    endfunction

    task automatic push_status(input logic [STATUS_W-1:0] st);
        out_t r;
        r             = '0;
        r.status      = st;
        r.last_result = 1'b1;
        split_q.insert(split_q.size(), r);
    endtask

    // Load one weight; on the closing beat solve the split and queue its beats.
    task automatic load_item(input in_t it);
        longint unsigned pre[MAX_ITEMS+1];
        longint unsigned best[MAX_ITEMS+1];
        int              from[MAX_ITEMS+1];
        bit              reach[MAX_ITEMS+1];
        int              bin_of[MAX_ITEMS];
        longint unsigned c, idle, cand, total, idle_sum, pen;
        int              n, node, bin;
        out_t            r;
        if (loaded_cnt < MAX_ITEMS) begin
            loaded[loaded_cnt] = it.item_weight;
            loaded_cnt++;
        end
        else
            dropped = 1;
        if (!it.last_item)
            return;
        n          = loaded_cnt;
        loaded_cnt = 0;
        if (dropped) begin
            dropped = 0;
            push_status(ST_TOO_MANY);
            return;
        end
        pre[0] = 0;
        for (int i = 0; i <= n; i++) begin
            best[i]  = 0;
            from[i]  = 0;
            reach[i] = 0;
            if (i > 0)
                pre[i] = pre[i-1] + loaded[i-1];
        end
        for (int i = 0; i < n; i++) begin
            if (i > 0 && !reach[i])
                continue;
            for (int j = i + 1; j <= n; j++) begin
                if (!fit_bin(pre[j] - pre[i], c, idle))
                    break;
                cand = best[i] + c;
                // keep the earlier predecessor on a tie
                if (!reach[j] || cand < best[j]) begin
                    best[j]  = cand;
                    from[j]  = i;
                    reach[j] = 1;
                end
            end
        end
        if (!reach[n]) begin
            push_status(ST_NO_SPLIT);
            return;
        end
        total    = best[n];
        idle_sum = 0;
        bin      = 1;
        node     = n;
        while (node > 0) begin
            void'(fit_bin(pre[node] - pre[from[node]], c, idle));
            idle_sum += idle;
            for (int j = from[node]; j < node; j++)
                bin_of[j] = bin;
            bin++;
            node = from[node];
        end
        if (pen_en) begin
            pen   = (idle_sum >= IDLE_SQ_LIMIT) ? COST_MAX : idle_sum * idle_sum;
            total = (pen > COST_MAX - total) ? COST_MAX : total + pen;
        end
        if (total > COST_MAX)
            total = COST_MAX;
        for (int j = 0; j < n; j++) begin
            r.item_index  = ITEM_INDEX_W'(j);
            r.bin_number  = BIN_NUMBER_W'(bin_of[j]);
            r.total_cost  = TOTAL_W'(total);
            r.status      = ST_OK;
            r.last_result = (j == n - 1);
            split_q.insert(split_q.size(), r);
        end
    endtask

    task automatic check_beat(input out_t got);
        out_t want;
        if (split_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat %p", $time, got);
            return;
        end
        want = split_q.pop_front();
        if (got.item_index !== want.item_index || got.bin_number !== want.bin_number
            || got.total_cost !== want.total_cost || got.status !== want.status
            || got.last_result !== want.last_result) begin
            errors++;
            $display("%0t: expected %p actual %p", $time, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_s = 0; cap_m = 0; cap_l = 0;
            cost_s = 0; cost_m = 0; cost_l = 0;
            pen_en = 0;
            loaded_cnt = 0;
            dropped = 0;
            errors = 0;
            split_q.delete();
        end
        else begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CFG_CAP_SMALL:   cap_s  = cfg_data;
                    CFG_CAP_MEDIUM:  cap_m  = cfg_data;
                    CFG_CAP_LARGE:   cap_l  = cfg_data;
                    CFG_COST_SMALL:  cost_s = cfg_data;
                    CFG_COST_MEDIUM: cost_m = cfg_data;
                    CFG_COST_LARGE:  cost_l = cfg_data;
                    CFG_PENALTY_EN:  pen_en = cfg_data[0];
                    default: ;
                endcase
            if (pop && !empty)
                check_beat(result);
            if (push && !full)
                load_item(item);
        end
    end

endmodule

### dv/variable_bin_split_cost_unit_tb.sv
// Testbench top for the variable bin split cost unit: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module variable_bin_split_cost_unit_tb;
    import vbsc_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    in_t                   item;
    logic                  full;
    logic                  empty;
    logic                  pop;
    out_t                  result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    cycles;
    int                    items_sent;
    int                    burst_left;
    bit                    steady;
    int unsigned           shadow_cap_l;

    variable_bin_split_cost_unit dut (
        .clk(clk), .rst_n(rst_n), .push(push), .item(item), .full(full),
        .empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    variable_bin_split_cost_checker chk (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .pop(pop), .empty(empty), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("variable_bin_split_cost_unit: mismatch");
            $finish;
        end
    end

    // Receiver: stall pattern changes mode every so often.
    initial
    begin
        int mode;
        int left;
        pop  = 0;
        mode = 0;
        left = 0;
        forever begin
            @(negedge clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(10, 200);
            end
            left--;
            case (mode)
                0: pop = 1;
                1: pop = ($urandom_range(0, 3) != 0);
                2: pop = ($urandom_range(0, 1) != 0);
                default: pop = ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    task automatic send_item(input logic [15:0] w, input logic last);
        if (burst_left == 0) begin
            if (!steady) begin
                push = 0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        push             = 1;
        item.item_weight = w;
        item.last_item   = last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
        if (!steady && burst_left == 0)
            push = 0;
    endtask

    task automatic drain();
        push = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data  = val;
        if (idx == CFG_CAP_LARGE)
            shadow_cap_l = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic set_all(input logic [15:0] cs, cm, cl, ks, km, kl, input bit pe);
        drain();
        write_reg(CFG_CAP_SMALL, cs);
        write_reg(CFG_CAP_MEDIUM, cm);
        write_reg(CFG_CAP_LARGE, cl);
        write_reg(CFG_COST_SMALL, ks);
        write_reg(CFG_COST_MEDIUM, km);
        write_reg(CFG_COST_LARGE, kl);
        write_reg(CFG_PENALTY_EN, {15'd0, pe});
    endtask

    // Mostly weights that fit the largest bin; a few anywhere in range.
    task automatic send_sequence(input int len);
        logic [15:0] w;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0)
                w = 16'($urandom_range(0, 65535));
            else
                w = 16'($urandom_range(0, shadow_cap_l));
            send_item(w, k == len - 1);
        end
    endtask

    initial
    begin
        int len;
        logic [15:0] c0, c1, c2;
        rst_n      = 0;
        push       = 0;
        item       = '0;
        cfg_valid  = 0;
        cfg_index  = '0;
        cfg_data   = '0;
        cycles     = 0;
        items_sent = 0;
        burst_left = 0;
        steady     = 0;
        shadow_cap_l = 0;
        repeat (12) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // reset config: only zero weights fit
        send_item(16'd0, 1);
        send_item(16'd1, 1);
        set_all(16'd100, 16'd200, 16'd400, 16'd3, 16'd5, 16'd8, 1'b0);
        send_item(16'd65535, 1);
        send_item(16'd50, 0); send_item(16'd50, 0); send_item(16'd50, 0);
        send_item(16'd50, 1);
        send_item(16'd400, 0); send_item(16'd1, 0); send_item(16'd399, 1);
        // unordered capacities and a penalty
        set_all(16'd500, 16'd100, 16'd300, 16'd7, 16'd1, 16'd2, 1'b1);
        send_item(16'd120, 0); send_item(16'd90, 0); send_item(16'd600, 1);
        send_item(16'd250, 0); send_item(16'd250, 1);
        // everything at its maximum, with the penalty enabled
        set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(16'd0, 0); send_item(16'hFFFF, 0); send_item(16'hAAAA, 0);
        send_item(16'h5555, 1);
        send_item(16'd0, 1);

        while (items_sent < 330) begin
            case ($urandom_range(0, 5))
                0: set_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           1'($urandom_range(0, 1)));
                1: set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 1'b1);
                default: begin
                    c0 = 16'($urandom_range(0, 20000));
                    c1 = 16'(c0 + $urandom_range(0, 20000));
                    c2 = 16'(c1 + $urandom_range(0, 25000));
                    set_all(c0, c1, c2, 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            1'($urandom_range(0, 1)));
                end
            endcase
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(3, 8)) begin
                case ($urandom_range(0, 39))
                    0:       len = $urandom_range(65, 70);
                    1, 2:    len = $urandom_range(30, 64);
                    default: len = $urandom_range(1, 8);
                endcase
                send_sequence(len);
            end
        end
        steady = 0;
        push   = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("variable_bin_split_cost_unit: match");
        else
            $display("variable_bin_split_cost_unit: mismatch");
        $finish;
    end

endmodule
